>>> hw/rtl/process_snapshot_diff_top_macros.svh
// assertion macros used by the checker file
`ifndef PROCESS_SNAPSHOT_DIFF_TOP_MACROS_SVH
`define PROCESS_SNAPSHOT_DIFF_TOP_MACROS_SVH

// checked property, suspended while reset is low
`define PSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property that also holds through reset
`define PSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/psd_pkg.sv
// shared types and constants of the process snapshot diff block
`timescale 1ns / 1ps
package psd_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] KIND_SPAWNED = 2'd0;
    localparam logic [1:0] KIND_TERMINATED = 2'd1;
    localparam logic [1:0] KIND_DROPPED = 2'd2;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    typedef struct packed {
        logic [31:0] ident;
        logic [63:0] start;
    } ent_t;

    localparam int ENT_W = $bits(ent_t);

    typedef struct packed {
        logic        is_close;
        logic [31:0] pid;
        logic [31:0] parent;
        logic [63:0] start;
    } cmd_t;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } fq_t;

endpackage

>>> hw/rtl/psd_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module psd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/psd_front.sv
// front end: accepts words, classifies them and queues commands
`timescale 1ns / 1ps
module psd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           op,
    input  logic [31:0]    pid,
    input  logic [31:0]    parent_pid,
    input  logic [63:0]    start_ms,
    output psd_pkg::fq_t   head,
    input  logic           pop
);

    psd_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;
    psd_pkg::cmd_t cmd_in;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;

    always_comb
    begin
        cmd_in.is_close = (op == psd_pkg::OP_CLOSE);
        cmd_in.pid = pid;
        cmd_in.parent = parent_pid;
        cmd_in.start = start_ms;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.cmd = q_reg[rd_ptr_reg];

endmodule

>>> hw/rtl/psd_back.sv
// back end: table search sequencer, table rams and result register
`timescale 1ns / 1ps
module psd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psd_pkg::fq_t          head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            kind,
    output logic [31:0]           proc_id,
    output logic [31:0]           parent_id,
    output logic                  last
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CUR_RD   = 4'd1;
    localparam logic [3:0] S_CUR_CMP  = 4'd2;
    localparam logic [3:0] S_NEW      = 4'd3;
    localparam logic [3:0] S_PRV_RD   = 4'd4;
    localparam logic [3:0] S_PRV_CMP  = 4'd5;
    localparam logic [3:0] S_TERM     = 4'd6;
    localparam logic [3:0] S_SPAWN    = 4'd7;
    localparam logic [3:0] S_OUT_RD   = 4'd8;
    localparam logic [3:0] S_IN_RD    = 4'd9;
    localparam logic [3:0] S_IN_CMP   = 4'd10;
    localparam logic [3:0] S_MISS     = 4'd11;
    localparam logic [3:0] S_NEXT_OUT = 4'd12;
    localparam logic [3:0] S_FLUSH    = 4'd13;
    localparam logic [3:0] S_SWAP     = 4'd14;

    logic [3:0]                 state_reg, state_next;
    logic [psd_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [psd_pkg::IDX_W-1:0]  oidx_reg, oidx_next;
    logic [psd_pkg::CNT_W-1:0]  cur_cnt_reg, cur_cnt_next;
    logic [psd_pkg::CNT_W-1:0]  prev_cnt_reg, prev_cnt_next;
    logic                       bank_reg, bank_next;
    logic                       primed_reg, primed_next;
    logic                       held_valid_reg, held_valid_next;
    logic [31:0]                held_id_reg, held_id_next;
    psd_pkg::cmd_t              cmd_reg, cmd_next;

    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 kind_reg;
    logic [31:0]                proc_id_reg;
    logic [31:0]                parent_id_reg;
    logic                       last_reg;

    logic                       push;
    logic [1:0]                 push_kind;
    logic [31:0]                push_id;
    logic [31:0]                push_parent;
    logic                       push_last;
    logic                       out_free;

    logic                       cur_we;
    logic [psd_pkg::IDX_W-1:0]  prev_raddr;
    psd_pkg::ent_t              wr_ent;
    psd_pkg::ent_t              cur_rd, prev_rd;
    logic [psd_pkg::ENT_W-1:0]  rdata0, rdata1;
    logic [psd_pkg::IDX_W-1:0]  raddr0, raddr1;
    logic                       idx_end_cur, idx_end_prev, oidx_end;

    // table banks: bank_reg selects which ram holds the current sample
    assign prev_raddr = cmd_reg.is_close ? oidx_reg : idx_reg;
    assign raddr0 = bank_reg ? prev_raddr : idx_reg;
    assign raddr1 = bank_reg ? idx_reg : prev_raddr;
    assign wr_ent.ident = cmd_reg.pid;
    assign wr_ent.start = cmd_reg.start;
    assign cur_rd = bank_reg ? psd_pkg::ent_t'(rdata1) : psd_pkg::ent_t'(rdata0);
    assign prev_rd = bank_reg ? psd_pkg::ent_t'(rdata0) : psd_pkg::ent_t'(rdata1);

    psd_ram #(.WIDTH(psd_pkg::ENT_W), .DEPTH(psd_pkg::TABLE_DEPTH)) u_ram0 (
        .clk   (clk),
        .we    (cur_we && !bank_reg),
        .waddr (cur_cnt_reg[psd_pkg::IDX_W-1:0]),
        .wdata (wr_ent),
        .raddr (raddr0),
        .rdata (rdata0)
    );

    psd_ram #(.WIDTH(psd_pkg::ENT_W), .DEPTH(psd_pkg::TABLE_DEPTH)) u_ram1 (
        .clk   (clk),
        .we    (cur_we && bank_reg),
        .waddr (cur_cnt_reg[psd_pkg::IDX_W-1:0]),
        .wdata (wr_ent),
        .raddr (raddr1),
        .rdata (rdata1)
    );

    assign idx_end_cur = (psd_pkg::CNT_W'(idx_reg) + psd_pkg::CNT_W'(1)) == cur_cnt_reg;
    assign idx_end_prev = (psd_pkg::CNT_W'(idx_reg) + psd_pkg::CNT_W'(1)) == prev_cnt_reg;
    assign oidx_end = (psd_pkg::CNT_W'(oidx_reg) + psd_pkg::CNT_W'(1)) == prev_cnt_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        oidx_next = oidx_reg;
        cur_cnt_next = cur_cnt_reg;
        prev_cnt_next = prev_cnt_reg;
        bank_next = bank_reg;
        primed_next = primed_reg;
        held_valid_next = held_valid_reg;
        held_id_next = held_id_reg;
        cmd_next = cmd_reg;
        pop = 1'b0;
        cur_we = 1'b0;
        push = 1'b0;
        push_kind = psd_pkg::KIND_SPAWNED;
        push_id = cmd_reg.pid;
        push_parent = 32'd0;
        push_last = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    cmd_next = head.cmd;
                    idx_next = '0;
                    oidx_next = '0;
                    if (!head.cmd.is_close)
                    begin
                        state_next = (cur_cnt_reg == '0) ? S_NEW : S_CUR_RD;
                    end
                    else
                    begin
                        state_next = (primed_reg && prev_cnt_reg != '0) ? S_OUT_RD : S_SWAP;
                    end
                end
            end
            S_CUR_RD:
            begin
                state_next = S_CUR_CMP;
            end
            S_CUR_CMP:
            begin
                if (cur_rd.ident == cmd_reg.pid)
                begin
                    state_next = S_IDLE;
                end
                else if (idx_end_cur)
                begin
                    state_next = S_NEW;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_CUR_RD;
                end
            end
            S_NEW:
            begin
                if (cur_cnt_reg == psd_pkg::CNT_W'(psd_pkg::TABLE_DEPTH))
                begin
                    push = 1'b1;
                    push_kind = psd_pkg::KIND_DROPPED;
                    push_last = 1'b1;
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cur_we = 1'b1;
                    cur_cnt_next = cur_cnt_reg + 1'b1;
                    idx_next = '0;
                    if (!primed_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = (prev_cnt_reg == '0) ? S_SPAWN : S_PRV_RD;
                    end
                end
            end
            S_PRV_RD:
            begin
                state_next = S_PRV_CMP;
            end
            S_PRV_CMP:
            begin
                if (prev_rd.ident == cmd_reg.pid)
                begin
                    state_next = (prev_rd.start != cmd_reg.start) ? S_TERM : S_IDLE;
                end
                else if (idx_end_prev)
                begin
                    state_next = S_SPAWN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_PRV_RD;
                end
            end
            S_TERM:
            begin
                push = 1'b1;
                push_kind = psd_pkg::KIND_TERMINATED;
                if (out_free)
                begin
                    state_next = S_SPAWN;
                end
            end
            S_SPAWN:
            begin
                push = 1'b1;
                push_kind = psd_pkg::KIND_SPAWNED;
                push_parent = cmd_reg.parent;
                push_last = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT_RD:
            begin
                idx_next = '0;
                state_next = (cur_cnt_reg == '0) ? S_MISS : S_IN_RD;
            end
            S_IN_RD:
            begin
                state_next = S_IN_CMP;
            end
            S_IN_CMP:
            begin
                if (cur_rd.ident == prev_rd.ident)
                begin
                    state_next = S_NEXT_OUT;
                end
                else if (idx_end_cur)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_IN_RD;
                end
            end
            S_MISS:
            begin
                // a terminated word goes out only once the next one is known
                if (held_valid_reg)
                begin
                    push = 1'b1;
                    push_kind = psd_pkg::KIND_TERMINATED;
                    push_id = held_id_reg;
                    if (out_free)
                    begin
                        held_id_next = prev_rd.ident;
                        state_next = S_NEXT_OUT;
                    end
                end
                else
                begin
                    held_valid_next = 1'b1;
                    held_id_next = prev_rd.ident;
                    state_next = S_NEXT_OUT;
                end
            end
            S_NEXT_OUT:
            begin
                if (oidx_end)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    oidx_next = oidx_reg + 1'b1;
                    state_next = S_OUT_RD;
                end
            end
            S_FLUSH:
            begin
                if (held_valid_reg)
                begin
                    push = 1'b1;
                    push_kind = psd_pkg::KIND_TERMINATED;
                    push_id = held_id_reg;
                    push_last = 1'b1;
                    if (out_free)
                    begin
                        held_valid_next = 1'b0;
                        state_next = S_SWAP;
                    end
                end
                else
                begin
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                bank_next = !bank_reg;
                prev_cnt_next = cur_cnt_reg;
                cur_cnt_next = '0;
                primed_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (push && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        held_id_reg <= held_id_next;
        if (push && out_free)
        begin
            kind_reg <= push_kind;
            proc_id_reg <= push_id;
            parent_id_reg <= push_parent;
            last_reg <= push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            oidx_reg <= '0;
            cur_cnt_reg <= '0;
            prev_cnt_reg <= '0;
            bank_reg <= 1'b0;
            primed_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            oidx_reg <= oidx_next;
            cur_cnt_reg <= cur_cnt_next;
            prev_cnt_reg <= prev_cnt_next;
            bank_reg <= bank_next;
            primed_reg <= primed_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign proc_id = proc_id_reg;
    assign parent_id = parent_id_reg;
    assign last = last_reg;

endmodule

>>> hw/rtl/process_snapshot_diff_top.sv
// top level of the process snapshot diff block
`timescale 1ns / 1ps
// process snapshot diff: a sample is a run of record words (op 0) closed by a
// close word (op 1); the block reports spawned pids, reused pids (terminated
// then spawned) and, on close, terminated pids missing from the new sample,
// in table slot order; the first sample only sets the baseline and a record
// that finds the table full gives one dropped word; the last flag marks the
// final result word of each input word.
// operation: each table is a ram with one write port, one read port and a
// registered read; entries are inspected one at a time, a read state then a
// compare state for each; a record searches the current table, then the
// previous one, then emits its result words, and a close walks the previous
// table and searches the current one for each entry; output stalls hold both;
// a two-word command queue lets words arrive while the back end is busy and a
// result register lets the next word start while a result waits to be taken;
// tables swap by flipping a bank select, so no copy or clearing pass is needed
module process_snapshot_diff_top (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] pid,
    input  logic [31:0] parent_pid,
    input  logic [63:0] start_ms,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] proc_id,
    output logic [31:0] parent_id,
    output logic        last
);

    // queue head handed from front to back end
    psd_pkg::fq_t head;
    logic         pop;

    psd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .pid        (pid),
        .parent_pid (parent_pid),
        .start_ms   (start_ms),
        .head       (head),
        .pop        (pop)
    );

    psd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .proc_id   (proc_id),
        .parent_id (parent_id),
        .last      (last)
    );

endmodule

>>> hw/rtl/psd_checker.sv
// port level checks of the process snapshot diff block
`timescale 1ns / 1ps
`include "process_snapshot_diff_top_macros.svh"
module psd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [31:0] proc_id,
    input logic [31:0] parent_id,
    input logic        last
);

    `PSD_ASSERT(a_out_hold,
        out_valid && out_stall |=> out_valid && $stable({kind, proc_id, parent_id, last}),
        "result word changed while stalled")
    `PSD_ASSERT(a_kind_code,
        out_valid |-> (kind == psd_pkg::KIND_SPAWNED || kind == psd_pkg::KIND_TERMINATED
                       || kind == psd_pkg::KIND_DROPPED),
        "undefined result kind")
    `PSD_ASSERT(a_parent_zero,
        out_valid && kind != psd_pkg::KIND_SPAWNED |-> parent_id == 32'd0,
        "parent set on non-spawn word")
    `PSD_ASSERT(a_drop_last,
        out_valid && kind == psd_pkg::KIND_DROPPED |-> last,
        "dropped word not marked last")
    `PSD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result word during reset")

endmodule

bind process_snapshot_diff_top psd_checker u_psd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .proc_id   (proc_id),
    .parent_id (parent_id),
    .last      (last)
);
